/* rtl/core/cits_pkg.sv */
`default_nettype none

package cits_pkg;

    localparam int CAPACITY = 64;
    localparam int ID_BITS  = 32;

    // identifiers are held in their low ID_BITS bits, never more than the field carries
    localparam int ID_W      = (ID_BITS < 32) ? ID_BITS : 32;
    localparam int IDX_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_GET    = 2'd3
    } cits_op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RESERVED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_INDEX = 3'd4
    } cits_status_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] id_value;
        logic [5:0]  slot_index;
    } cits_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  position;
        logic [31:0] read_value;
        logic [6:0]  entry_count;
    } cits_out_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic            add;
        logic            rem;
        logic [ID_W-1:0] key;
    } cits_ctl_t;

    // what the row reports back to the sequencer
    typedef struct packed {
        logic                found;
        logic [IDX_BITS-1:0] pos;
        logic [ID_W-1:0]     rd_value;
    } cits_row_t;

endpackage

`default_nettype wire

/* rtl/core/cits_cell.sv */
`default_nettype none

module cits_cell (
    input  wire logic                          clk,
    input  wire cits_pkg::cits_ctl_t           ctl,
    input  wire logic                          occupied,
    input  wire logic                          add_here,
    input  wire logic                          seen_in,
    input  wire logic [cits_pkg::ID_W-1:0]     next_value,
    output logic                               seen_out,
    output logic                               first_hit,
    output logic [cits_pkg::ID_W-1:0]          value
);
    import cits_pkg::*;

    logic [ID_W-1:0] value_reg;
    logic            hit;

    assign hit       = occupied && (value_reg == ctl.key);
    assign seen_out  = seen_in || hit;
    assign first_hit = hit && !seen_in;
    assign value     = value_reg;

    // add fills the end slot; remove shifts entries down from the first match
    always_ff @(posedge clk)
    begin
        if (ctl.add && add_here)
        begin
            value_reg <= ctl.key;
        end
        else if (ctl.rem && seen_out)
        begin
            value_reg <= next_value;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cits_row.sv */
`default_nettype none

module cits_row (
    input  wire logic                          clk,
    input  wire cits_pkg::cits_ctl_t           ctl,
    input  wire logic [cits_pkg::CNT_BITS-1:0] count,
    input  wire logic [cits_pkg::IDX_BITS-1:0] rd_idx,
    output cits_pkg::cits_row_t                row
);
    import cits_pkg::*;

    logic [CAPACITY:0]   seen;
    logic [CAPACITY-1:0] first_hit;
    logic [CAPACITY-1:0] rd_sel;
    logic [ID_W-1:0]     value [CAPACITY];
    logic [ID_W-1:0]     rd_or;
    logic [IDX_BITS-1:0] pos_or;

    assign seen[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ID_W-1:0] up_value;

        if (i == CAPACITY - 1)
        begin : g_top
            assign up_value = value[i];
        end
        else
        begin : g_mid
            assign up_value = value[i+1];
        end

        assign rd_sel[i] = (rd_idx == IDX_BITS'(i));

        cits_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occupied   (CNT_BITS'(i) < count),
            .add_here   (CNT_BITS'(i) == count),
            .seen_in    (seen[i]),
            .next_value (up_value),
            .seen_out   (seen[i+1]),
            .first_hit  (first_hit[i]),
            .value      (value[i])
        );
    end

    always_comb
    begin
        rd_or  = '0;
        pos_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_or  = rd_or | (value[i] & {ID_W{rd_sel[i]}});
            pos_or = pos_or | (IDX_BITS'(i) & {IDX_BITS{first_hit[i]}});
        end
    end

    assign row.found    = seen[CAPACITY];
    assign row.pos      = pos_or;
    assign row.rd_value = rd_or;

endmodule

`default_nettype wire

/* rtl/core/compacting_id_set_table_unit.sv */
// Ordered table of up to 64 identifiers kept packed from slot 0.
// Requests arrive on in_valid/in_ready with in_data (op, id_value, slot_index);
// each request gives exactly one beat on out_valid/out_ready with out_data
// (status, position, read_value, entry_count after the request).
// Operations: add appends at the end, remove deletes the first match and
// closes the gap, find reports the first matching slot, get reads one slot.
// A request is loaded into the request register on accept; in the execute
// state the row commits it and the result register is loaded. The row of 64
// cells compares every entry at once, ripples the first-match flag along it
// and shifts all later entries down at once, so one request is in work at a
// time. in_ready is high when no request is in work and the result register
// is empty or being taken in the same cycle. A stalled result holds its beat;
// the next request waits until it is taken. reserved_id is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while idle, which the
// block does not enforce. reserved_id resets to all ones. Reset empties the
// table (count zero) and drops any result.
`default_nettype none

module compacting_id_set_table_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [31:0]         cfg_wr_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cits_pkg::cits_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cits_pkg::cits_out_t      out_data
);
    import cits_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t              state_reg;
    cits_in_t            req_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic [ID_W-1:0]     reserved_reg;
    logic                out_valid_reg;
    cits_out_t           out_reg;
    cits_out_t           out_next;

    cits_ctl_t           ctl;
    cits_row_t           row;
    logic                is_reserved;
    logic                accept;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign is_reserved = (req_reg.id_value[ID_W-1:0] == reserved_reg);

    always_comb
    begin
        ctl.add    = 1'b0;
        ctl.rem    = 1'b0;
        ctl.key    = req_reg.id_value[ID_W-1:0];
        count_next = count_reg;
        out_next   = '0;
        out_next.status = ST_OK;

        case (cits_op_t'(req_reg.op))
            OP_ADD:
            begin
                if (is_reserved)
                begin
                    out_next.status = ST_RESERVED;
                end
                else if (count_reg == CNT_BITS'(CAPACITY))
                begin
                    out_next.status = ST_FULL;
                end
                else
                begin
                    ctl.add    = (state_reg == S_EXEC);
                    count_next = count_reg + CNT_BITS'(1);
                end
            end
            OP_REMOVE:
            begin
                if (is_reserved)
                begin
                    out_next.status = ST_RESERVED;
                end
                else if (!row.found)
                begin
                    out_next.status = ST_NOT_FOUND;
                end
                else
                begin
                    ctl.rem    = (state_reg == S_EXEC);
                    count_next = count_reg - CNT_BITS'(1);
                end
            end
            OP_FIND:
            begin
                if (is_reserved)
                begin
                    out_next.status = ST_RESERVED;
                end
                else if (!row.found)
                begin
                    out_next.status = ST_NOT_FOUND;
                end
                else
                begin
                    out_next.position = 6'(row.pos);
                end
            end
            OP_GET:
            begin
                if ((CNT_BITS + 1)'(req_reg.slot_index) >= (CNT_BITS + 1)'(count_reg))
                begin
                    out_next.status = ST_BAD_INDEX;
                end
                else
                begin
                    out_next.read_value = 32'(row.rd_value);
                end
            end
            default:
            begin
                out_next.status = ST_OK;
            end
        endcase

        out_next.entry_count = 7'(count_next);
    end

    cits_row u_row (
        .clk    (clk),
        .ctl    (ctl),
        .count  (count_reg),
        .rd_idx (req_reg.slot_index),
        .row    (row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            count_reg     <= '0;
            reserved_reg  <= '1;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                reserved_reg <= cfg_wr_data[ID_W-1:0];
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (out_valid_reg && out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        req_reg   <= in_data;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    count_reg     <= count_next;
                    out_reg       <= out_next;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cits_checker.sv */
`default_nettype none

module cits_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire cits_pkg::cits_out_t out_data
);
    import cits_pkg::*;

    // every accepted request is followed by its result beat on out_valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##2 out_valid)
    else $error("result beat missing two cycles after accept");

    // only one request in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.entry_count <= 7'(CAPACITY))
                      && (out_data.status <= 3'(ST_BAD_INDEX)))
    else $error("entry count or status out of range");

    // position and read data are only carried by a successful request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((out_data.position != '0) || (out_data.read_value != '0)))
        |-> (out_data.status == 3'(ST_OK)))
    else $error("payload on a failed request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind compacting_id_set_table_unit cits_checker u_cits_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
